[rtl/dpw_pkg.sv]
package dpw_pkg;

  // Width of the sequence number field on the request channel.
  localparam int SEQ_IN_W = 16;

  // Distance margin below the map depth beyond which the whole map is cleared.
  localparam int FLUSH_MARGIN = 4;

  typedef enum logic {
    REQ_CHECK = 1'b0,
    REQ_MARK  = 1'b1
  } req_e;

endpackage

[rtl/dpw_req_if.sv]
interface dpw_req_if;
  logic                           valid;
  logic                           ready;
  dpw_pkg::req_e                  req_type;
  logic [dpw_pkg::SEQ_IN_W-1:0]   seq_number;

  modport source (output valid, req_type, seq_number, input ready);
  modport sink   (input valid, req_type, seq_number, output ready);
endinterface

[rtl/dpw_res_if.sv]
interface dpw_res_if;
  logic valid;
  logic ready;
  logic deliver;
  logic window_advanced;
  logic map_flushed;

  modport source (output valid, deliver, window_advanced, map_flushed, input ready);
  modport sink   (input valid, deliver, window_advanced, map_flushed, output ready);
endinterface

[rtl/duplicate_packet_window.sv]
// A request beat passes the input register, the product register, the slot register and
// the result register in turn. Throughput: one beat per cycle while results are taken;
// every stage, the result register included, moves on as soon as the stage after it has
// room. A result that is not taken stalls intake only once all four stages hold a beat.
// Reset: asynchronous and active low; the delivered map is cleared at once, the newest
// number and its slot go to zero, and no clearing pass follows.

module duplicate_packet_window #(
  parameter int SEQ_BITS  = 16,
  parameter int MAP_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpw_req_if.sink   req_i,
  dpw_res_if.source res_o
);

  localparam int SLOT_W = $clog2(MAP_DEPTH);

  // Between the two parts travels one request beat with its slot index already
  // worked out, so the window stage only compares and updates state.
  logic                         slot_valid;
  logic                         slot_ready;
  dpw_pkg::req_e                slot_req;
  logic [dpw_pkg::SEQ_IN_W-1:0] slot_seq;
  logic [SLOT_W-1:0]            slot_idx;

  // Input register, then the number modulo the depth: a multiplication by the
  // rounded-up reciprocal, and in the next stage the subtraction of the
  // quotient times the depth. None of this reads window state.
  dpw_slot_calc #(
    .SEQ_BITS  (SEQ_BITS),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_slot_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (slot_valid),
    .ready_i (slot_ready),
    .req_o   (slot_req),
    .seq_o   (slot_seq),
    .slot_o  (slot_idx)
  );

  // Window stage: the newer test, the clear of skipped slots by range compare
  // over the flop bitmap (or a flush on a large jump), the mark of a slot, and
  // the result register. State is read and written here only, so back-to-back
  // beats see each other's updates without forwarding.
  dpw_window #(
    .SEQ_BITS  (SEQ_BITS),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (slot_valid),
    .ready_o (slot_ready),
    .req_i   (slot_req),
    .seq_i   (slot_seq),
    .slot_i  (slot_idx),
    .res_o   (res_o)
  );

endmodule

[rtl/dpw_slot_calc.sv]
module dpw_slot_calc #(
  parameter int SEQ_BITS  = 16,
  parameter int MAP_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dpw_req_if.sink                      req_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output dpw_pkg::req_e                req_o,
  output logic [dpw_pkg::SEQ_IN_W-1:0] seq_o,
  output logic [$clog2(MAP_DEPTH)-1:0] slot_o
);

  localparam int IN_W    = dpw_pkg::SEQ_IN_W;
  localparam int SLOT_W  = $clog2(MAP_DEPTH);
  localparam int KSH     = IN_W + SLOT_W;
  localparam int RECIP_W = IN_W + 2;
  localparam int PROD_W  = IN_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - KSH;
  localparam int REM_W   = IN_W + SLOT_W + 1;
  localparam logic [63:0] SEQ_MASK = (64'd1 << SEQ_BITS) - 64'd1;
  // Rounded-up reciprocal of the depth; exact quotient for every 16-bit input.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << KSH) + 64'(MAP_DEPTH) - 64'd1) / 64'(MAP_DEPTH));

  logic                s0_valid_q, s1_valid_q, s2_valid_q;
  logic                s0_ready, s1_ready, s2_ready;
  dpw_pkg::req_e       s0_req_q, s1_req_q, s2_req_q;
  logic [IN_W-1:0]     s0_seq_q, s1_seq_q, s2_seq_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic [QUOT_W-1:0]   quot;
  logic [REM_W-1:0]    rem;
  logic [SLOT_W-1:0]   slot_q;
  logic [IN_W-1:0]     seq_masked;

  assign seq_masked = req_i.seq_number & SEQ_MASK[IN_W-1:0];

  assign s2_ready    = !s2_valid_q || ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign s0_ready    = !s0_valid_q || s1_ready;
  assign req_i.ready = s0_ready;

  assign prod_d = PROD_W'(s0_seq_q) * PROD_W'(RECIP);
  assign quot   = prod_q[PROD_W-1:KSH];
  assign rem    = REM_W'(s1_seq_q) - REM_W'(quot) * REM_W'(MAP_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= req_i.valid;
      end
      if (s1_ready) begin
        s1_valid_q <= s0_valid_q;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && s0_ready) begin
      s0_req_q <= req_i.req_type;
      s0_seq_q <= seq_masked;
    end
    if (s0_valid_q && s1_ready) begin
      s1_req_q <= s0_req_q;
      s1_seq_q <= s0_seq_q;
      prod_q   <= prod_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_req_q <= s1_req_q;
      s2_seq_q <= s1_seq_q;
      slot_q   <= rem[SLOT_W-1:0];
    end
  end

  assign valid_o = s2_valid_q;
  assign req_o   = s2_req_q;
  assign seq_o   = s2_seq_q;
  assign slot_o  = slot_q;

endmodule

[rtl/dpw_window.sv]
module dpw_window #(
  parameter int SEQ_BITS  = 16,
  parameter int MAP_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  dpw_pkg::req_e                req_i,
  input  logic [dpw_pkg::SEQ_IN_W-1:0] seq_i,
  input  logic [$clog2(MAP_DEPTH)-1:0] slot_i,
  dpw_res_if.source                    res_o
);

  localparam int SLOT_W = $clog2(MAP_DEPTH);
  localparam logic [63:0] SEQ_MASK  = (64'd1 << SEQ_BITS) - 64'd1;
  localparam logic [63:0] FLUSH_LIM = 64'(MAP_DEPTH - dpw_pkg::FLUSH_MARGIN);
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SEQ_MASK % 64'(MAP_DEPTH));
  localparam logic [SLOT_W-1:0] TOP_SLOT    = SLOT_W'(MAP_DEPTH - 1);

  logic [SEQ_BITS-1:0]  newest_q, seq, fwd_dist;
  logic [SLOT_W-1:0]    newest_slot_q, slot_next, hi_a;
  logic [MAP_DEPTH-1:0] map_q, map_d;
  logic                 out_valid_q, deliver_q, advanced_q, flushed_q;
  logic                 fire, is_check, advance, flush, wrap, en_a, en_b, deliver;

  assign ready_o  = !out_valid_q || res_o.ready;
  assign fire     = valid_i && ready_o;
  assign is_check = (req_i == dpw_pkg::REQ_CHECK);

  assign seq      = SEQ_BITS'(seq_i);
  assign fwd_dist = seq - newest_q;
  assign advance  = is_check && (fwd_dist != '0) && !fwd_dist[SEQ_BITS-1];
  assign flush    = 64'(fwd_dist) > FLUSH_LIM;

  // A newer number below the newest one means the sequence space wrapped; the
  // skipped numbers then form two runs: newest+1 to the top, and zero to seq.
  assign wrap      = seq < newest_q;
  assign slot_next = (newest_slot_q == TOP_SLOT) ? '0 : newest_slot_q + 1'b1;
  assign hi_a      = wrap ? LAST_SLOT : slot_i;
  assign en_a      = !(wrap && (64'(newest_q) == SEQ_MASK));
  assign en_b      = wrap;

  always_comb begin
    logic [SLOT_W-1:0] idx;
    logic              in_a, in_b, clr;
    map_d = map_q;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      idx  = SLOT_W'(i);
      in_a = (slot_next <= hi_a) ? (idx >= slot_next && idx <= hi_a)
                                 : (idx >= slot_next || idx <= hi_a);
      in_b = idx <= slot_i;
      clr  = advance && (flush || (en_a && in_a) || (en_b && in_b));
      map_d[i] = (map_q[i] && !clr) || (!is_check && idx == slot_i);
    end
  end

  // The slot of a number that just advanced the window is always in the
  // cleared run, so it is delivered.
  assign deliver = is_check && (advance || !map_q[slot_i]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      newest_q      <= '0;
      newest_slot_q <= '0;
      map_q         <= '0;
    end else begin
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
      if (fire) begin
        map_q <= map_d;
        if (advance) begin
          newest_q      <= seq;
          newest_slot_q <= slot_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      deliver_q  <= deliver;
      advanced_q <= advance;
      flushed_q  <= advance && flush;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.deliver         = deliver_q;
  assign res_o.window_advanced = advanced_q;
  assign res_o.map_flushed     = flushed_q;

endmodule

[bench/duplicate_packet_window_tb.sv]
`timescale 1ns / 1ps

// Testbench for the duplicate packet window. Request beats come from a queue
// that the stimulus process fills before reset is released. A clocked driver
// offers them in bursts, and a clocked monitor checks each result beat
// against the verdicts that a local copy of the window predicts at the
// moment each request beat is accepted.
module duplicate_packet_window_tb;

  localparam int SEQ_BITS   = 16;
  localparam int MAP_DEPTH  = 256;
  localparam int CLK_PERIOD = 20;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_BEATS = 1300;
  // The receiver holds off once, for this many cycles, after this many results.
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 500;
  localparam logic [SEQ_BITS-1:0] HALF_RANGE = SEQ_BITS'(1) << (SEQ_BITS - 1);

  // One request beat. When drain_first is set, the driver waits until every
  // verdict already owed has come back before it offers this beat.
  typedef struct packed {
    dpw_pkg::req_e kind;
    logic [15:0]   seq;
    logic          drain_first;
  } packet_t;

  // What the block should answer for one request beat.
  typedef struct packed {
    logic deliver;
    logic window_advanced;
    logic map_flushed;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dpw_req_if req_if ();
  dpw_res_if res_if ();

  duplicate_packet_window #(
    .SEQ_BITS (SEQ_BITS),
    .MAP_DEPTH(MAP_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  packet_t  packet_q[$];
  verdict_t verdict_q[$];
  int       errors = 0;

  // Local copy of the window state. Reset happens only once, so the
  // declaration values stand for the state after reset.
  logic [SEQ_BITS-1:0] window_newest = '0;
  bit                  slot_taken[MAP_DEPTH];

  // Works out the verdict for one request and advances the local window.
  function automatic verdict_t judge_packet(dpw_pkg::req_e kind, logic [15:0] seq_in);
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] fwd_dist;
    logic [SEQ_BITS-1:0] skipped;
    verdict_t            v;
    v   = '0;
    seq = seq_in[SEQ_BITS-1:0];
    if (kind == dpw_pkg::REQ_MARK) begin
      slot_taken[seq % MAP_DEPTH] = 1'b1;
    end else begin
      fwd_dist = seq - window_newest;
      if (fwd_dist != 0 && fwd_dist < HALF_RANGE) begin
        if (fwd_dist > MAP_DEPTH - dpw_pkg::FLUSH_MARGIN) begin
          // The jump is too large to clear slot by slot, so the map starts over.
          foreach (slot_taken[i]) slot_taken[i] = 1'b0;
          v.map_flushed = 1'b1;
        end else begin
          // Clear every slot the window slides over, the new number's included.
          for (int k = 1; k <= fwd_dist; k++) begin
            skipped = window_newest + SEQ_BITS'(k);
            slot_taken[skipped % MAP_DEPTH] = 1'b0;
          end
        end
        window_newest     = seq;
        v.window_advanced = 1'b1;
      end
      // An old number still reads its slot, even when a newer number reused it.
      v.deliver = !slot_taken[seq % MAP_DEPTH];
    end
    return v;
  endfunction

  task automatic add_packet(dpw_pkg::req_e kind, logic [15:0] seq, logic drain_first);
    packet_t p;
    p.kind        = kind;
    p.seq         = seq;
    p.drain_first = drain_first;
    packet_q.push_back(p);
  endtask

  // Driver. The sender works in bursts of random length with random gaps.
  // A beat that is offered stays on the bus until it is taken.
  int      burst_left;
  int      gap_left;
  packet_t next_packet;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.req_type   <= dpw_pkg::REQ_CHECK;
      req_if.seq_number <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        verdict_q.push_back(judge_packet(req_if.req_type, req_if.seq_number));
      end
      if (req_if.valid && !req_if.ready) begin
        // Hold the current beat.
      end else if (gap_left != 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (packet_q.size() != 0 &&
                   !(packet_q[0].drain_first && verdict_q.size() != 0)) begin
        next_packet = packet_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.req_type   <= next_packet.kind;
        req_if.seq_number <= next_packet.seq;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          // A quarter of the bursts run straight into the next one.
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver. Ready follows a pattern that changes mode now and then: always
  // ready, ready at random, or rarely ready. Once, after enough results, it
  // holds off long enough for the block to fill up and stall its input.
  int mode;
  int mode_left;
  int hold_left;
  bit hold_done;
  int results_taken;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      mode          = 0;
      mode_left     = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
      results_taken = 0;
    end else begin
      if (res_if.valid && res_if.ready) results_taken++;
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(2);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= 1'($urandom_range(1));
          default: res_if.ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // Monitor. Every result beat must match the oldest verdict still owed.
  verdict_t got;
  verdict_t want;

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.deliver         = res_if.deliver;
      got.window_advanced = res_if.window_advanced;
      got.map_flushed     = res_if.map_flushed;
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with nothing owed: deliver=%b advanced=%b flushed=%b",
                 $time, got.deliver, got.window_advanced, got.map_flushed);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected deliver=%b advanced=%b flushed=%b, got %b %b %b",
                   $time, want.deliver, want.window_advanced, want.map_flushed,
                   got.deliver, got.window_advanced, got.map_flushed);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat on either side is a hang.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  logic [15:0]   gen_newest;
  logic [15:0]   gen_seq;
  logic [15:0]   gen_dist;
  dpw_pkg::req_e gen_kind;
  int            pick;

  initial begin
    rst_ni = 1'b0;

    // Directed part. A fresh map delivers and a mark turns the number into a
    // duplicate.
    add_packet(dpw_pkg::REQ_CHECK, 16'h0000, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'h0000, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'h0000, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'h0001, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'h0001, 1'b0);
    // A jump of exactly depth minus the margin still clears slot by slot.
    add_packet(dpw_pkg::REQ_CHECK, 16'd253, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'd253, 1'b0);
    // An old number whose slot a newer one has taken reads as a duplicate.
    add_packet(dpw_pkg::REQ_CHECK, 16'hFFFD, 1'b0);
    // One step further and the whole map is flushed.
    add_packet(dpw_pkg::REQ_CHECK, 16'd506, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'd253, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'hFFFF, 1'b0);
    // The largest forward distance that still counts as newer.
    add_packet(dpw_pkg::REQ_CHECK, 16'd506 + 16'h7FFF, 1'b0);
    // Exactly half the range ahead is not newer.
    add_packet(dpw_pkg::REQ_CHECK, 16'd506 + 16'hFFFF, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'hFFFF, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'h0000, 1'b0);
    // The window slides across the wrap of the sequence space.
    add_packet(dpw_pkg::REQ_CHECK, 16'h0002, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'h0000, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'h8000, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'h8000, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'hFFFF, 1'b0);
    add_packet(dpw_pkg::REQ_MARK,  16'h5555, 1'b0);
    add_packet(dpw_pkg::REQ_CHECK, 16'hAAAA, 1'b0);
    gen_newest = 16'hFFFF;

    // Random part. Most beats follow a live stream: small steps forward,
    // marks of recent numbers and replays, with some jumps around the flush
    // boundary and some far off. The rest is noise.
    for (int i = 0; i < RAND_BEATS; i++) begin
      pick     = $urandom_range(99);
      gen_kind = dpw_pkg::REQ_CHECK;
      if (pick < 35) begin
        gen_seq = gen_newest + 16'($urandom_range(1, 6));
      end else if (pick < 40) begin
        gen_seq = gen_newest + 16'($urandom_range(245, 262));
      end else if (pick < 44) begin
        gen_seq = gen_newest + 16'($urandom_range(263, 65535));
      end else if (pick < 70) begin
        gen_kind = dpw_pkg::REQ_MARK;
        gen_seq  = gen_newest - 16'($urandom_range(0, 12));
      end else if (pick < 88) begin
        gen_seq = gen_newest - 16'($urandom_range(0, 300));
      end else begin
        gen_kind = dpw_pkg::req_e'($urandom_range(1));
        gen_seq  = 16'($urandom_range(0, 65535));
      end
      gen_dist = gen_seq - gen_newest;
      if (gen_kind == dpw_pkg::REQ_CHECK && gen_dist != 0 && gen_dist < 16'h8000) begin
        gen_newest = gen_seq;
      end
      // Now and then the sender pauses until every result is back.
      add_packet(gen_kind, gen_seq, (i == 0) || (i % 400 == 399));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (packet_q.size() != 0 || req_if.valid || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    // Give a stray extra result time to show up.
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dpw_pkg.sv
rtl/dpw_req_if.sv
rtl/dpw_res_if.sv
rtl/dpw_slot_calc.sv
rtl/dpw_window.sv
rtl/duplicate_packet_window.sv
bench/duplicate_packet_window_tb.sv
